// ===== src/kdeg_pkg.sv =====
// Shared types and constants of the key debounce event generator.
// Used by every module in src; has no dependencies of its own.
`default_nettype none

package kdeg_pkg;

  // Field and register widths
  localparam int unsigned LEVELS_W   = 4;
  localparam int unsigned FILTER_W   = 7;
  localparam int unsigned LONG_W     = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned KEY_IDX_W  = 2;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Keys that have a level bit and a long-press register
  localparam int unsigned LONG_REGS    = 4;
  localparam int unsigned NUM_KEYS_DEF = 4;

  // Reset values
  localparam logic [FILTER_W-1:0] FILTER_RESET = 7'd5;
  localparam logic [LONG_W-1:0]   LONG_RESET   = 16'd100;
  localparam logic [CNT_W-1:0]    CNT_RESET    = CNT_W'(FILTER_RESET / 2);

  // Event slots per key in the pending mask, in delivery order
  localparam int unsigned EV_SLOTS     = 3;
  localparam int unsigned SLOT_PRESS   = 0;
  localparam int unsigned SLOT_LONG    = 1;
  localparam int unsigned SLOT_RELEASE = 2;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_LONG    = 2'd2
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER = 3'd0,
    REG_LONG0  = 3'd1,
    REG_LONG1  = 3'd2,
    REG_LONG2  = 3'd3,
    REG_LONG3  = 3'd4
  } cfg_reg_e;

  // Events raised by one key on one tick
  typedef struct packed {
    logic press;
    logic long_press;
    logic release_ev;
  } key_ev_t;

endpackage

`default_nettype wire

// ===== src/key_debounce_event_generator_core.sv =====
// Top level of the key debounce event generator: config registers, tick
// register, per-key filters and the event queue. Depends on kdeg_pkg,
// kdeg_key_filter and kdeg_event_queue.
//
// Usage:
//   Each request on the input channel (in_valid_i / in_stall_o) is one scan
//   tick with the pressed level of every key. The tick is held in an input
//   register; once the queue can take it, all key filters update at once
//   and the tick's events load into a pending mask. Events leave on the
//   output channel (out_valid_o / out_stall_i) one per cycle unless stalled,
//   in key order, press before long press, with last_event_o set on the
//   final one of a tick. With an idle queue the first event of a tick is
//   valid once the pending mask has loaded it from the input register.
//   A tick raises at most 8 events for four keys; a tick with no events
//   leaves the queue ready, so ticks can follow back to back. The queue
//   drain is the limiting unit. A stalled output holds its event; the
//   input register stalls only once it is full and the queue cannot take
//   its events.
//   Reset: filter time 5, every long time 100, debounce counts 2, all keys
//   released, hold counts 0, no pending events.
//   Config writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at once;
//   unknown indexes are ignored.
`default_nettype none

module key_debounce_event_generator_core #(
  parameter int unsigned NUM_KEYS = kdeg_pkg::NUM_KEYS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [kdeg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [kdeg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [kdeg_pkg::LEVELS_W-1:0]    pressed_levels_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [kdeg_pkg::KEY_IDX_W-1:0]        key_index_o,
  output logic [kdeg_pkg::KIND_W-1:0]           event_kind_o,
  output logic                                  last_event_o
);

  localparam int unsigned MaskW = kdeg_pkg::EV_SLOTS * NUM_KEYS;

  logic [kdeg_pkg::FILTER_W-1:0] filter_q;
  logic [kdeg_pkg::LONG_W-1:0]   long_q [kdeg_pkg::LONG_REGS];
  logic                          in_valid_q;
  logic [kdeg_pkg::LEVELS_W-1:0] levels_q;
  logic                          q_ready;
  logic                          upd;
  logic [MaskW-1:0]              mask;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= kdeg_pkg::FILTER_RESET;
      for (int i = 0; i < kdeg_pkg::LONG_REGS; i++) begin
        long_q[i] <= kdeg_pkg::LONG_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kdeg_pkg::REG_FILTER: filter_q  <= cfg_wdata_i[kdeg_pkg::FILTER_W-1:0];
        kdeg_pkg::REG_LONG0:  long_q[0] <= cfg_wdata_i;
        kdeg_pkg::REG_LONG1:  long_q[1] <= cfg_wdata_i;
        kdeg_pkg::REG_LONG2:  long_q[2] <= cfg_wdata_i;
        kdeg_pkg::REG_LONG3:  long_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register: process the held tick when the queue can take it
  assign upd        = in_valid_q && q_ready;
  assign in_stall_o = in_valid_q && !q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (upd) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      levels_q <= pressed_levels_i;
    end
  end

  // One filter per key; keys without a level bit read released
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    logic                        pressed;
    logic [kdeg_pkg::LONG_W-1:0] lt;
    kdeg_pkg::key_ev_t           ev;

    if (k < kdeg_pkg::LONG_REGS) begin : g_wired
      assign pressed = levels_q[k];
      assign lt      = long_q[k];
    end else begin : g_idle
      assign pressed = 1'b0;
      assign lt      = '0;
    end

    kdeg_key_filter u_filter (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .upd_i     (upd),
      .pressed_i (pressed),
      .filter_i  (filter_q),
      .long_i    (lt),
      .ev_o      (ev)
    );

    assign mask[kdeg_pkg::EV_SLOTS*k + kdeg_pkg::SLOT_PRESS]   = ev.press;
    assign mask[kdeg_pkg::EV_SLOTS*k + kdeg_pkg::SLOT_LONG]    = ev.long_press;
    assign mask[kdeg_pkg::EV_SLOTS*k + kdeg_pkg::SLOT_RELEASE] = ev.release_ev;
  end

  kdeg_event_queue #(
    .NUM_KEYS (NUM_KEYS)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (upd),
    .mask_i       (mask),
    .ready_o      (q_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_index_o  (key_index_o),
    .event_kind_o (event_kind_o),
    .last_event_o (last_event_o)
  );

endmodule

`default_nettype wire

// ===== src/kdeg_key_filter.sv =====
// Debounce counter, key state and hold counter of one key.
// Depends on kdeg_pkg.
`default_nettype none

module kdeg_key_filter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           upd_i,
  input  wire logic                           pressed_i,
  input  wire logic [kdeg_pkg::FILTER_W-1:0]  filter_i,
  input  wire logic [kdeg_pkg::LONG_W-1:0]    long_i,
  output kdeg_pkg::key_ev_t                   ev_o
);

  logic [kdeg_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        down_q, down_d;
  logic [kdeg_pkg::LONG_W-1:0] hold_q, hold_d;
  logic [kdeg_pkg::CNT_W-1:0]  ft;
  logic [kdeg_pkg::CNT_W-1:0]  full;
  logic [kdeg_pkg::LONG_W-1:0] hold_inc;

  assign ft       = kdeg_pkg::CNT_W'(filter_i);
  assign full     = {filter_i, 1'b0};
  assign hold_inc = hold_q + 1'b1;

  // Work out next state and events of this tick
  always_comb begin
    cnt_d  = cnt_q;
    down_d = down_q;
    hold_d = hold_q;
    ev_o   = '0;
    if (pressed_i) begin
      if (cnt_q < ft) begin
        cnt_d = ft;
      end else if (cnt_q < full) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        if (!down_q) begin
          down_d   = 1'b1;
          ev_o.press = 1'b1;
        end
        if ((long_i != '0) && (hold_q < long_i)) begin
          hold_d = hold_inc;
          if (hold_inc == long_i) begin
            ev_o.long_press = 1'b1;
          end
        end
      end
    end else begin
      if (cnt_q > ft) begin
        cnt_d = ft;
      end else if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end else if (down_q) begin
        down_d          = 1'b0;
        ev_o.release_ev = 1'b1;
      end
      hold_d = '0;
    end
    if (!upd_i) begin
      ev_o = '0;
    end
  end

  // Advance state on each processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= kdeg_pkg::CNT_RESET;
      down_q <= 1'b0;
      hold_q <= '0;
    end else if (upd_i) begin
      cnt_q  <= cnt_d;
      down_q <= down_d;
      hold_q <= hold_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/kdeg_event_queue.sv =====
// Pending event mask of one tick, drained lowest slot first, one per cycle unless stalled.
// Depends on kdeg_pkg.
`default_nettype none

module kdeg_event_queue #(
  parameter int unsigned NUM_KEYS = kdeg_pkg::NUM_KEYS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  load_i,
  input  wire logic [kdeg_pkg::EV_SLOTS*NUM_KEYS-1:0] mask_i,
  output logic                                       ready_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [kdeg_pkg::KEY_IDX_W-1:0]             key_index_o,
  output logic [kdeg_pkg::KIND_W-1:0]                event_kind_o,
  output logic                                       last_event_o
);

  localparam int unsigned MaskW = kdeg_pkg::EV_SLOTS * NUM_KEYS;

  logic [MaskW-1:0]      mask_q, mask_d;
  logic [MaskW-1:0]      low;
  logic                  fire;
  kdeg_pkg::event_kind_e kind;

  // Pick the lowest pending slot
  assign low          = mask_q & (~mask_q + 1'b1);
  assign out_valid_o  = (mask_q != '0);
  assign last_event_o = ((mask_q & ~low) == '0);
  assign fire         = out_valid_o && !out_stall_i;
  assign ready_o      = !out_valid_o || (fire && last_event_o);

  // Decode key and kind of the selected slot
  always_comb begin
    key_index_o = '0;
    kind        = kdeg_pkg::EV_PRESS;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (low[kdeg_pkg::EV_SLOTS*k + kdeg_pkg::SLOT_PRESS]) begin
        key_index_o = kdeg_pkg::KEY_IDX_W'(k);
        kind        = kdeg_pkg::EV_PRESS;
      end
      if (low[kdeg_pkg::EV_SLOTS*k + kdeg_pkg::SLOT_LONG]) begin
        key_index_o = kdeg_pkg::KEY_IDX_W'(k);
        kind        = kdeg_pkg::EV_LONG;
      end
      if (low[kdeg_pkg::EV_SLOTS*k + kdeg_pkg::SLOT_RELEASE]) begin
        key_index_o = kdeg_pkg::KEY_IDX_W'(k);
        kind        = kdeg_pkg::EV_RELEASE;
      end
    end
  end
  assign event_kind_o = kind;

  // Load a new tick, or drop the delivered event
  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = mask_i;
    end else if (fire) begin
      mask_d = mask_q & ~low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  // Exactly one slot is selected while an event is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(low))
    else $error("selected slot not one-hot");

  // A new tick never overwrites events still to be delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && out_valid_o) |-> (fire && last_event_o))
    else $error("pending events overwritten");

  // A stalled event stays selected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && !load_i) |=> (out_valid_o && $stable(low)))
    else $error("stalled event changed");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for key_debounce_event_generator_core: scan ticks in, key events out.
// Holds its own debounce and event predictor; depends on kdeg_pkg and the core RTL.

module tb_top;
  import kdeg_pkg::*;

  localparam int unsigned NKEYS          = NUM_KEYS_DEF;
  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned PRESSURE_AT    = 40;
  localparam int unsigned PRESSURE_LEN   = 150;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(REG_LONG3) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key;
    event_kind_e          kind;
    logic                 last;
  } key_event_t;

  // Clock, reset and block ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  tick_valid = 1'b0;
  logic                  tick_stall;
  logic [LEVELS_W-1:0]   tick_levels = '0;
  logic                  event_valid;
  logic                  event_stall = 1'b0;
  logic [KEY_IDX_W-1:0]  event_key;
  logic [KIND_W-1:0]     event_kind;
  logic                  event_last;

  // Predictor state and settings
  logic [FILTER_W-1:0] filter_time_m;
  logic [LONG_W-1:0]   long_time_m [NKEYS];
  logic [CNT_W-1:0]    debounce_cnt [NKEYS];
  logic                key_is_down [NKEYS];
  logic [LONG_W-1:0]   hold_cnt [NKEYS];

  logic [LEVELS_W-1:0] scan_queue [$];
  key_event_t          expected_events [$];
  logic [LEVELS_W-1:0] held_levels = '0;

  int unsigned cycle_count = 0;
  int unsigned ticks_accepted = 0;
  int unsigned events_checked = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;

  // Driver and receiver scratch
  logic drv_hold, drv_load;
  int   send_gap = 0;
  int   send_calm = 0;
  int   stall_left = 0;
  int   recv_calm = 0;
  bit   pressure_done = 1'b0;
  key_event_t got_expected;

  key_debounce_event_generator_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (tick_valid),
    .in_stall_o       (tick_stall),
    .pressed_levels_i (tick_levels),
    .out_valid_o      (event_valid),
    .out_stall_i      (event_stall),
    .key_index_o      (event_key),
    .event_kind_o     (event_kind),
    .last_event_o     (event_last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bring the predictor to its reset state
  function automatic void reset_predictor();
    filter_time_m = FILTER_RESET;
    for (int k = 0; k < NKEYS; k++) begin
      long_time_m[k]  = LONG_RESET;
      debounce_cnt[k] = CNT_RESET;
      key_is_down[k]  = 1'b0;
      hold_cnt[k]     = '0;
    end
  endfunction

  function automatic key_event_t make_event(input int k, input event_kind_e kind);
    key_event_t ev;
    ev.key  = KEY_IDX_W'(k);
    ev.kind = kind;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Advance every key filter by one scan tick and queue the events it raises
  function automatic void debounce_tick(input logic [LEVELS_W-1:0] levels);
    key_event_t tick_events [$];
    int full;
    full = 2 * int'(filter_time_m);
    for (int k = 0; k < NKEYS; k++) begin
      if (levels[k]) begin
        if (debounce_cnt[k] < filter_time_m) begin
          debounce_cnt[k] = CNT_W'(filter_time_m);
        end else if (int'(debounce_cnt[k]) < full) begin
          debounce_cnt[k] = debounce_cnt[k] + 1'b1;
        end else begin
          if (!key_is_down[k]) begin
            key_is_down[k] = 1'b1;
            tick_events.push_back(make_event(k, EV_PRESS));
          end
          if (long_time_m[k] != 0 && hold_cnt[k] < long_time_m[k]) begin
            hold_cnt[k] = hold_cnt[k] + 1'b1;
            if (hold_cnt[k] == long_time_m[k]) tick_events.push_back(make_event(k, EV_LONG));
          end
        end
      end else begin
        if (debounce_cnt[k] > filter_time_m) begin
          debounce_cnt[k] = CNT_W'(filter_time_m);
        end else if (debounce_cnt[k] != 0) begin
          debounce_cnt[k] = debounce_cnt[k] - 1'b1;
        end else if (key_is_down[k]) begin
          key_is_down[k] = 1'b0;
          tick_events.push_back(make_event(k, EV_RELEASE));
        end
        hold_cnt[k] = '0;
      end
    end
    if (tick_events.size() != 0) tick_events[tick_events.size() - 1].last = 1'b1;
    foreach (tick_events[i]) expected_events.push_back(tick_events[i]);
  endfunction

  // Mostly short gaps, a few long ones, now and then a stretch with none
  function automatic int idle_length(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(8, 25);
    calm = $urandom_range(20, 60);
    return 0;
  endfunction

  // Keys hold their level for runs of ticks; a few ticks carry glitches or noise
  function automatic logic [LEVELS_W-1:0] next_scan();
    logic [LEVELS_W-1:0] lv;
    for (int k = 0; k < NKEYS; k++) begin
      if ($urandom_range(0, 4) == 0) held_levels[k] = ~held_levels[k];
    end
    lv = held_levels;
    if ($urandom_range(0, 11) == 0) lv[$urandom_range(0, NKEYS - 1)] ^= 1'b1;
    if ($urandom_range(0, 9) == 0) lv = LEVELS_W'($urandom);
    return lv;
  endfunction

  function automatic logic [LONG_W-1:0] pick_long_time();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return '0;
    if (r == 3) return '1;
    if (r == 4) return LONG_W'($urandom_range(7, 65535));
    return LONG_W'($urandom_range(1, 6));
  endfunction

  // Write one register and mirror it into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_FILTER: filter_time_m = data[FILTER_W-1:0];
      REG_LONG0:  long_time_m[0] = data;
      REG_LONG1:  long_time_m[1] = data;
      REG_LONG2:  long_time_m[2] = data;
      REG_LONG3:  long_time_m[3] = data;
      default: ;
    endcase
  endtask

  task automatic write_long_times(input logic [LONG_W-1:0] l0, input logic [LONG_W-1:0] l1,
                                  input logic [LONG_W-1:0] l2, input logic [LONG_W-1:0] l3);
    write_reg(REG_LONG0, l0);
    write_reg(REG_LONG1, l1);
    write_reg(REG_LONG2, l2);
    write_reg(REG_LONG3, l3);
    settings_used++;
  endtask

  // Filter time with junk in the upper data bits, random hold times, maybe a stray index
  task automatic random_settings(input logic [FILTER_W-1:0] filt);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom);
    w[FILTER_W-1:0] = filt;
    write_reg(REG_FILTER, w);
    write_long_times(pick_long_time(), pick_long_time(), pick_long_time(), pick_long_time());
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                CFG_DATA_W'($urandom));
    end
  endtask

  task automatic queue_scans(input logic [LEVELS_W-1:0] lv, input int count);
    repeat (count) scan_queue.push_back(lv);
  endtask

  task automatic queue_random_scans(input int count);
    repeat (count) scan_queue.push_back(next_scan());
  endtask

  // Drain all requests and events, then let the core settle with no input
  task automatic drain_and_settle();
    @(negedge clk_i);
    while (scan_queue.size() != 0 || tick_valid || expected_events.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Offer scan ticks; predict each one as it is accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      drv_hold = tick_valid;
      drv_load = 1'b0;
      if (tick_valid && !tick_stall) begin
        debounce_tick(tick_levels);
        ticks_accepted <= ticks_accepted + 1;
        drv_hold = 1'b0;
      end
      if (!drv_hold) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (scan_queue.size() != 0) begin
          tick_levels <= scan_queue.pop_front();
          send_gap = idle_length(send_calm);
          drv_load = 1'b1;
        end
      end
      tick_valid <= drv_hold | drv_load;
    end
  end

  // Check each accepted event against the oldest prediction, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (event_valid && !event_stall) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: key_index %0d event_kind %0d last_event %0d",
                 event_key, event_kind, event_last);
          mismatches++;
        end else begin
          got_expected = expected_events.pop_front();
          events_checked++;
          if (event_key !== got_expected.key) begin
            $error("key_index: expected %0d, got %0d", got_expected.key, event_key);
            mismatches++;
          end
          if (event_kind !== got_expected.kind) begin
            $error("event_kind: expected %0d, got %0d", got_expected.kind, event_kind);
            mismatches++;
          end
          if (event_last !== got_expected.last) begin
            $error("last_event: expected %0d, got %0d", got_expected.last, event_last);
            mismatches++;
          end
        end
      end
      // Hold off once for a long stretch so the core backs up into its input
      if (!pressure_done && ticks_accepted >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left = PRESSURE_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        event_stall <= 1'b1;
      end else begin
        stall_left = idle_length(recv_calm);
        event_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d events outstanding",
               cycle_count, expected_events.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus: directed corner cases, then random phases under several settings
  initial begin
    reset_predictor();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: debounce from the half-filter start count up to the full count, short of a press
    queue_scans(4'hF, 6);
    drain_and_settle();

    // Filter 1 with masked upper bits, mixed hold times, stray register index
    write_reg(REG_FILTER, 16'hFF81);
    write_long_times(16'd1, 16'd2, 16'd0, 16'hFFFF);
    write_reg(REG_UNUSED_FIRST, 16'h0000);
    queue_scans(4'h0, 3);
    queue_scans(4'hF, 4);
    queue_scans(4'h5, 1);
    queue_scans(4'hA, 1);
    drain_and_settle();

    // Filter zero: pressed is full at once, released drops straight to zero
    write_reg(REG_FILTER, 16'd0);
    settings_used++;
    queue_scans(4'h0, 1);
    queue_scans(4'hF, 1);
    queue_scans(4'h3, 1);
    queue_scans(4'hC, 1);
    drain_and_settle();

    // Build up hold counts, then lower both times under the held counts
    write_reg(REG_FILTER, 16'd2);
    write_long_times(16'd3, 16'd3, 16'd3, 16'd3);
    queue_scans(4'hF, 6);
    drain_and_settle();
    write_reg(REG_FILTER, 16'd1);
    write_long_times(16'd1, 16'd1, 16'd1, 16'd1);
    queue_scans(4'hF, 2);
    queue_scans(4'h0, 3);
    drain_and_settle();

    // Random phases; the slowest filter sits before a fast one
    random_settings(FILTER_W'($urandom_range(0, 3)));
    queue_random_scans(15);
    drain_and_settle();
    random_settings(FILTER_W'($urandom_range(1, 3)));
    queue_random_scans(15);
    drain_and_settle();
    random_settings(FILTER_W'($urandom_range(0, 2)));
    queue_random_scans(15);
    drain_and_settle();
    write_reg(REG_FILTER, 16'd127);
    write_long_times('1, '1, '1, '1);
    queue_random_scans(10);
    drain_and_settle();
    random_settings(FILTER_W'($urandom_range(0, 3)));
    queue_random_scans(20);
    drain_and_settle();
    random_settings(FILTER_W'($urandom_range(1, 4)));
    queue_random_scans(15);
    drain_and_settle();

    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      mismatches++;
    end
    $display("Sent %0d scan ticks under %0d register settings and checked %0d key events.",
             ticks_accepted, settings_used, events_checked);
    $display("Filter times 0 to 127, hold times off to maximum, one long output hold-off.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
